>>> rtl/pvd_pkg.sv
// Shared types and constants of the peak/valley detector.
`default_nettype none

package pvd_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned ThrWidth     = 23;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] RegDetectValleys  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegBackoffSamples = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegHeightThresh   = 2'd2;

  // Reset values of the registers
  localparam logic [CfgDataWidth-1:0] BackoffReset = 32'd1000;
  localparam logic [ThrWidth-1:0]     ThreshReset  = 23'd15;

  typedef struct packed {
    logic                    detect_valleys;
    logic [CfgDataWidth-1:0] backoff_samples;
    logic [ThrWidth-1:0]     height_threshold;
  } pvd_cfg_t;

endpackage

`default_nettype wire

>>> rtl/pvd_cfg.sv
// Configuration register file of the peak/valley detector.
`default_nettype none

module pvd_cfg
  import pvd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output      logic                    cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  output      pvd_cfg_t                cfg_o
);

  pvd_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_valleys   <= 1'b0;
      cfg_q.backoff_samples  <= BackoffReset;
      cfg_q.height_threshold <= ThreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDetectValleys:  cfg_q.detect_valleys   <= cfg_data_i[0];
        RegBackoffSamples: cfg_q.backoff_samples  <= cfg_data_i;
        RegHeightThresh:   cfg_q.height_threshold <= cfg_data_i[ThrWidth-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/pvd_core.sv
// Detection state and single-pass peak/valley decision logic.
`default_nettype none

module pvd_core
  import pvd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire pvd_cfg_t                       cfg_i,
  output      logic                           found_o,
  output      logic        [COUNT_WIDTH-1:0]  ago_o,
  output      logic signed [SAMPLE_WIDTH-1:0] level_o
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned EW = SW + ThrWidth + 1;   // compare width, never wraps
  localparam int unsigned BW = CfgDataWidth + 1;    // backoff compare width

  localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic        [CW-1:0] CMax = {CW{1'b1}};

  function automatic logic signed [SW-1:0] neg_sat(input logic signed [SW-1:0] v);
    return (v == SMin) ? SMax : -v;
  endfunction

  logic signed [SW-1:0] older_q, middle_q, newest_q, cand_q, valley_q;
  logic signed [SW-1:0] older_d, middle_d, newest_d, cand_d, valley_d;
  logic        [CW-1:0] age_q, slp_q, age_d, slp_d;

  logic signed [SW-1:0] cand_upd, valley_upd;
  logic        [CW-1:0] age_inc, slp_inc, age_upd;
  logic signed [EW-1:0] mid_x, cand_x, valley_x, thr_x;
  logic                 is_max, is_min, take, found;

  always_comb begin
    // window shift, sample negated in valley mode
    older_d  = middle_q;
    middle_d = newest_q;
    newest_d = cfg_i.detect_valleys ? neg_sat(sample_i) : sample_i;

    age_inc = (age_q == CMax) ? age_q : age_q + CW'(1);
    slp_inc = (slp_q == CMax) ? slp_q : slp_q + CW'(1);

    is_max = (older_d <= middle_d) && (newest_d <= middle_d);
    is_min = (older_d >= middle_d) && (newest_d >= middle_d);

    mid_x    = EW'(middle_d);
    valley_x = EW'(valley_q);
    thr_x    = EW'($signed({1'b0, cfg_i.height_threshold}));

    // new candidate at a local maximum
    take = is_max && (middle_d > cand_q) && (mid_x > valley_x + thr_x) &&
           (BW'(slp_inc) > BW'(cfg_i.backoff_samples));
    cand_upd = take ? middle_d : cand_q;
    age_upd  = take ? CW'(1) : age_inc;

    // confirm at a local minimum
    cand_x = EW'(cand_upd);
    found  = is_min && (cand_x > mid_x + thr_x);

    cand_d     = found ? SMin : cand_upd;
    slp_d      = found ? age_upd : slp_inc;
    age_d      = age_upd;
    valley_upd = found ? SMax : valley_q;
    valley_d   = (is_min && (middle_d <= valley_upd)) ? middle_d : valley_upd;

    found_o = found;
    ago_o   = found ? age_upd : '0;
    level_o = found ? (cfg_i.detect_valleys ? neg_sat(cand_upd) : cand_upd) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      middle_q <= '0;
      newest_q <= '0;
      cand_q   <= SMin;
      valley_q <= SMax;
      age_q    <= '0;
      slp_q    <= '0;
    end else if (fire_i) begin
      older_q  <= older_d;
      middle_q <= middle_d;
      newest_q <= newest_d;
      cand_q   <= cand_d;
      valley_q <= valley_d;
      age_q    <= age_d;
      slp_q    <= slp_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pvd_obuf.sv
// Output register with skid stage for the result stream.
`default_nettype none

module pvd_obuf #(
  parameter int unsigned DATA_WIDTH = 57
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [DATA_WIDTH-1:0] in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [DATA_WIDTH-1:0] out_data_o
);

  logic                  main_v_q, skid_v_q;
  logic [DATA_WIDTH-1:0] main_q, skid_q;
  logic                  in_fire, main_free;

  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign main_free  = !main_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (main_free) begin
      main_v_q <= skid_v_q || in_fire;
      skid_v_q <= 1'b0;
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= in_data_i;
      end
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

>>> rtl/peak_valley_detector.sv
// Top level of the streaming peak/valley detector.
`default_nettype none

// Peak/valley detector: takes one signed sample per transfer and returns exactly
// one result per sample. The sample enters a three-sample window; a local
// maximum above the current candidate, higher than the running valley by more
// than height_threshold, and arriving after backoff_samples samples since the
// last report becomes the new candidate. A later local minimum more than
// height_threshold below the candidate confirms it: the result carries
// peak_found = 1, the candidate's age in samples (saturating) and its level.
// Otherwise the result is all zeros. With detect_valleys = 1 samples are
// negated (saturating) on entry and the reported level is negated back, so
// valleys are found instead. Throughput is one sample per clock while the
// input is ready: all decision logic is one combinational pass from the state
// registers into a result register. A skid stage behind the result register
// keeps the input ready while one result waits, so a stalled output side stops
// the input only after two results are pending. Configuration writes complete
// in the cycle they are presented and are meant for an idle block.
module peak_valley_detector
  import pvd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]        cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]       cfg_data_i,
  // sample stream
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,  // sample_in
  // result stream
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output      logic [((COUNT_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
                                             // samples_ago, peak_level
  output      logic                          m_axis_tuser_o   // peak_found
);

  localparam int unsigned OutW = ((COUNT_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned PW   = 1 + SAMPLE_WIDTH + COUNT_WIDTH;

  pvd_cfg_t cfg;

  logic                           s_fire;
  logic                           found;
  logic        [COUNT_WIDTH-1:0]  ago;
  logic signed [SAMPLE_WIDTH-1:0] level;
  logic        [PW-1:0]           res_in, res_out;

  // register file
  pvd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // state advances on every accepted sample
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  pvd_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s_fire),
    .sample_i ($signed(s_axis_tdata_i[SAMPLE_WIDTH-1:0])),
    .cfg_i    (cfg),
    .found_o  (found),
    .ago_o    (ago),
    .level_o  (level)
  );

  // pack result: flag on top, then level, then age in the low bits
  assign res_in = {found, level, ago};

  pvd_obuf #(
    .DATA_WIDTH (PW)
  ) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_fire),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (res_in),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_out)
  );

  assign m_axis_tuser_o = res_out[PW-1];
  assign m_axis_tdata_o = OutW'(res_out[PW-2:0]);

`ifndef ASSERT_OFF
  // input back-pressure only when a result is already waiting
  a_ready_implies_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o
  ) else $error("input stalled with no result pending");

  // accepting into a full, stalled output fills the skid stage
  a_skid_fill : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_fire && m_axis_tvalid_o && !m_axis_tready_i |=> !s_axis_tready_o
  ) else $error("skid stage did not take the stalled result");

  // results without a peak carry zero payload
  a_no_peak_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o == '0)
  ) else $error("no-peak result with nonzero payload");

  // a confirmed peak is at least one sample old
  a_peak_age : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (res_out[COUNT_WIDTH-1:0] != '0)
  ) else $error("confirmed peak with zero age");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the streaming peak/valley detector.
module testbench
  import pvd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW = 24;
  localparam int unsigned CountW  = 32;
  localparam longint      SampMax = 64'sd8388607;
  localparam longint      SampMin = -64'sd8388608;
  // Register index that the block does not decode; writes to it must be dropped.
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0]         count_t;

  typedef struct {
    bit      found;
    count_t  ago;
    sample_t level;
  } peak_report_t;

  // Scoreboard: runs its own copy of the detector on every accepted sample
  // and holds the reports that the block still owes.
  class peak_tracker;
    // shadow of the configuration registers
    bit                  valleys;
    count_t              backoff;
    logic [ThrWidth-1:0] threshold;
    // shadow of the detector state
    sample_t older, middle, newest, cand_peak, valley;
    count_t  cand_age, since_peak;
    peak_report_t awaited_reports[$];
    int errors;

    function new();
      valleys    = 1'b0;
      backoff    = BackoffReset;
      threshold  = ThreshReset;
      older      = '0;
      middle     = '0;
      newest     = '0;
      cand_peak  = sample_t'(SampMin);
      valley     = sample_t'(SampMax);
      cand_age   = '0;
      since_peak = '0;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return awaited_reports.size();
    endfunction

    // Mirror a register write; upper bits beyond each width are dropped.
    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        RegDetectValleys:  valleys = data[0];
        RegBackoffSamples: backoff = data;
        RegHeightThresh:   threshold = data[ThrWidth-1:0];
        default: ;
      endcase
    endfunction

    // Negate with saturation at the sample range.
    function sample_t negate_sat(longint v);
      longint r;
      r = -v;
      if (r > SampMax) r = SampMax;
      if (r < SampMin) r = SampMin;
      return sample_t'(r);
    endfunction

    function count_t bump(count_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    // Advance the shadow detector by one sample and queue the report it yields.
    function void note_sample(logic [SampleW-1:0] raw);
      longint s, thr, o, m, n;
      peak_report_t rep;
      s   = longint'($signed(raw));
      thr = longint'(threshold);
      rep = '{found: 1'b0, ago: '0, level: '0};
      if (valleys) s = longint'(negate_sat(s));
      older  = middle;
      middle = newest;
      newest = sample_t'(s);
      cand_age   = bump(cand_age);
      since_peak = bump(since_peak);
      o = longint'(older);
      m = longint'(middle);
      n = longint'(newest);
      // local maximum: promote to candidate if prominent and out of back-off
      if (o <= m && n <= m) begin
        if (m > longint'(cand_peak) && m > longint'(valley) + thr && since_peak > backoff) begin
          cand_peak = middle;
          cand_age  = count_t'(1);
        end
      end
      // local minimum: confirm a candidate that stands high enough above it
      if (o >= m && n >= m) begin
        if (longint'(cand_peak) > m + thr) begin
          rep.found  = 1'b1;
          rep.ago    = cand_age;
          rep.level  = valleys ? negate_sat(longint'(cand_peak)) : cand_peak;
          since_peak = cand_age;
          cand_peak  = sample_t'(SampMin);
          valley     = sample_t'(SampMax);
        end
        if (m <= longint'(valley)) valley = middle;
      end
      awaited_reports.push_back(rep);
    endfunction

    task check_result(bit found, count_t ago, sample_t level);
      peak_report_t want;
      if (awaited_reports.size() == 0) begin
        report($sformatf("result with no sample pending: found=%0b ago=%0d level=%0d",
                         found, ago, level));
      end else begin
        want = awaited_reports.pop_front();
        if (found !== want.found)
          report($sformatf("peak_found %0b, want %0b", found, want.found));
        if (ago !== want.ago)
          report($sformatf("samples_ago %0d, want %0d", ago, want.ago));
        if (level !== want.level)
          report($sformatf("peak_level %0d, want %0d", level, want.level));
      end
    endtask
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i  = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic [SampleW-1:0]      s_axis_tdata_i  = '0;
  logic                    m_axis_tready_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    s_axis_tready_o;
  logic                    m_axis_tvalid_o;
  logic [CountW+SampleW-1:0] m_axis_tdata_o;
  logic                    m_axis_tuser_o;

  peak_tracker tracker;
  bit     calm;          // no idling on either side
  bit     hold_request;  // ask the receiver for one long stall
  longint walk_level;    // running position of the random sample walk

  peak_valley_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // sample_in
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // samples_ago, peak_level
    .m_axis_tuser_o  (m_axis_tuser_o)    // peak_found
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Check every result transfer at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_result(m_axis_tuser_o, m_axis_tdata_o[CountW-1:0],
                           m_axis_tdata_o[CountW+SampleW-1:CountW]);
  end

  // Receiver: ready most of the time, short random stalls, one long hold-off
  // on request so the block fills up and drops its input ready.
  initial begin
    int n;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        n = 60;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        n = $urandom_range(1, 4);
      end else begin
        m_axis_tready_i <= 1'b1;
        n = 1;
      end
      repeat (n) @(negedge clk_i);
    end
  end

  // Present one register write and hold until it is taken; the caller drops valid.
  task write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Write all three registers plus a stray write to the unused index.
  task configure(logic [CfgDataWidth-1:0] valleys_word, logic [CfgDataWidth-1:0] backoff,
                 logic [CfgDataWidth-1:0] thr_word);
    write_reg(RegDetectValleys, valleys_word);
    write_reg(RegBackoffSamples, backoff);
    write_reg(RegHeightThresh, thr_word);
    write_reg(RegUnused, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample, optionally after a short idle burst; valid stays high after.
  task send_sample(logic [SampleW-1:0] s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_sample(s);
    @(negedge clk_i);
  endtask

  // Hold off until every owed report has come back.
  task drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Mostly a random walk scaled to the threshold so peaks get confirmed,
  // with extremes and fully random words mixed in.
  function logic [SampleW-1:0] pick_sample(longint span);
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      case ($urandom_range(0, 3))
        0: walk_level = SampMin;
        1: walk_level = SampMax;
        2: walk_level = 0;
        default: walk_level = -1;
      endcase
    end else if (kind <= 2) begin
      walk_level = longint'($signed(SampleW'($urandom)));
    end else begin
      walk_level = walk_level + longint'($urandom_range(0, 32'(2 * span))) - span;
      if (walk_level > SampMax) walk_level = SampMax;
      if (walk_level < SampMin) walk_level = SampMin;
    end
    return SampleW'(walk_level);
  endfunction

  task run_phase(int items, logic [CfgDataWidth-1:0] valleys_word,
                 logic [CfgDataWidth-1:0] backoff, logic [ThrWidth-1:0] thr);
    longint span;
    // random junk above the threshold width must be ignored
    configure(valleys_word, backoff, {9'($urandom_range(0, 511)), thr});
    span = 2 * longint'(thr) + 8;
    if (span > SampMax) span = SampMax;
    walk_level = 0;
    for (int i = 0; i < items; i++) begin
      send_sample(pick_sample(span));
    end
    drain();
  endtask

  initial begin
    sample_t opening[$];
    tracker = new();
    calm = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: full-scale extremes, nothing can be confirmed yet
    opening = '{0, 8388607, -8388608, -8388608, 8388607, 8388607, 0, -1};
    foreach (opening[i]) send_sample(opening[i]);
    drain();

    // Valley mode with junk in the upper bits, no back-off, small threshold;
    // includes negating the most negative sample
    configure(32'h8000_0003, 32'd0, 32'hFF80_0004);
    opening = '{0, -10, -40, -10, 30, 60, 30, -8388608, 0, 20, -8388608, 10,
                8388607, -8388608, 8388607, 0};
    foreach (opening[i]) send_sample(opening[i]);
    drain();

    // Random phases across the register extremes
    run_phase(115, 32'd0, 32'd0, 23'd0);
    run_phase(110, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'h7F_FFFF);
    hold_request = 1'b1;
    run_phase(115, {10'($urandom_range(0, 1023)), 22'd0},
              $urandom_range(0, 30), 23'($urandom_range(0, 200)));
    run_phase(115, {31'($urandom), 1'b1}, $urandom_range(0, 30),
              23'($urandom_range(0, 200)));
    run_phase(110, 32'd0, 32'd1000, 23'h7F_FFFF);
    calm = 1'b1;
    run_phase(120, $urandom, $urandom_range(0, 10), 23'($urandom_range(0, 60)));

    // Let the pipeline settle, then judge
    repeat (8) @(negedge clk_i);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pvd_pkg.sv
rtl/pvd_cfg.sv
rtl/pvd_core.sv
rtl/pvd_obuf.sv
rtl/peak_valley_detector.sv
dv/testbench.sv
